// ===== hdl/i2cmes_pkg.sv =====
`default_nettype none

package i2cmes_pkg;

    // input item opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;

    // bus controller status codes
    localparam logic [7:0] SC_START        = 8'h08;
    localparam logic [7:0] SC_RESTART      = 8'h10;
    localparam logic [7:0] SC_ADDR_W_ACK   = 8'h18;
    localparam logic [7:0] SC_ADDR_W_NACK  = 8'h20;
    localparam logic [7:0] SC_DATA_W_ACK   = 8'h28;
    localparam logic [7:0] SC_DATA_W_NACK  = 8'h30;
    localparam logic [7:0] SC_ARB_LOST     = 8'h38;
    localparam logic [7:0] SC_ADDR_R_ACK   = 8'h40;
    localparam logic [7:0] SC_ADDR_R_NACK  = 8'h48;
    localparam logic [7:0] SC_DATA_R_ACK   = 8'h50;
    localparam logic [7:0] SC_DATA_R_NACK  = 8'h58;

    // address byte plus first data byte are consumed by one address ack
    localparam logic [7:0] ADDR_ACK_STEP = 8'd2;

    // bus actions
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_CLEAR_START = 3'd1;
    localparam logic [2:0] ACT_STOP        = 3'd2;
    localparam logic [2:0] ACT_RESTART     = 3'd3;
    localparam logic [2:0] ACT_ACK         = 3'd4;

    // transfer status
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WRITE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_READ_COUNT   = 2'd1;
    localparam logic [1:0] CFG_REPEAT_START = 2'd2;
    localparam logic [1:0] CFG_READ_ADDRESS = 2'd3;

    typedef struct packed {
        logic [4:0] write_count;
        logic [7:0] read_count;
        logic       repeat_start_enable;
        logic [7:0] read_address;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] status_code;
        logic [7:0] data_byte;
        logic [3:0] buffer_index;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] bus_action;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic [1:0] transfer_status;
    } result_t;

    typedef struct packed {
        logic    tx_from_buf;
        result_t res;
    } stage_t;

endpackage

`default_nettype wire

// ===== hdl/i2cmes_wbuf.sv =====
`default_nettype none

module i2cmes_wbuf #(
    parameter int WRITE_DEPTH = 16,
    parameter int PW          = 4
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [PW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [PW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [WRITE_DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/i2cmes_ctrl.sv =====
`default_nettype none

module i2cmes_ctrl #(
    parameter int WRITE_DEPTH = 16,
    parameter int PW          = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                item_accept,
    input  wire i2cmes_pkg::item_t   item,
    input  wire i2cmes_pkg::cfg_t    cfg,
    input  wire logic                stage_ready,
    output logic                     stage_valid,
    output i2cmes_pkg::stage_t       stage,
    output logic                     buf_wr_en,
    output logic [PW-1:0]            buf_wr_addr,
    output logic                     buf_rd_en,
    output logic [PW-1:0]            buf_rd_addr
);

    import i2cmes_pkg::*;

    logic [PW-1:0] write_position_reg, write_position_next;
    logic [7:0]    write_remaining_reg, write_remaining_next;
    logic [7:0]    read_remaining_reg, read_remaining_next;
    logic [7:0]    read_position_reg, read_position_next;
    logic          repeat_pending_reg, repeat_pending_next;
    logic [1:0]    status_now_reg, status_now_next;
    logic          stage_valid_reg, stage_valid_next;
    stage_t        stage_reg, stage_next;
    logic [PW-1:0] pos_inc;
    logic          is_event;

    assign is_event = item_accept && (item.opcode == OP_EVENT);
    assign pos_inc  = (write_position_reg == PW'(WRITE_DEPTH - 1)) ?
                      '0 : write_position_reg + PW'(1);

    // buffer load, slots past the depth are dropped
    assign buf_wr_en   = item_accept && (item.opcode == OP_LOAD) &&
                         (9'(item.buffer_index) < 9'(WRITE_DEPTH));
    assign buf_wr_addr = PW'(item.buffer_index);
    assign buf_rd_en   = is_event;

    // transfer sequencing and event decode
    always_comb begin
        write_position_next  = write_position_reg;
        write_remaining_next = write_remaining_reg;
        read_remaining_next  = read_remaining_reg;
        read_position_next   = read_position_reg;
        repeat_pending_next  = repeat_pending_reg;
        status_now_next      = status_now_reg;
        stage_next           = '0;
        buf_rd_addr          = write_position_reg;

        if (item_accept && (item.opcode == OP_START)) begin
            write_position_next  = '0;
            write_remaining_next = 8'(cfg.write_count);
            read_remaining_next  = cfg.read_count;
            read_position_next   = '0;
            repeat_pending_next  = cfg.repeat_start_enable;
            status_now_next      = ST_BUSY;
        end else if (is_event) begin
            case (item.status_code)
                SC_START: begin
                    stage_next.res.bus_action = ACT_CLEAR_START;
                    stage_next.res.tx_valid   = 1'b1;
                    stage_next.tx_from_buf    = 1'b1;
                end
                SC_RESTART: begin
                    stage_next.res.bus_action = ACT_CLEAR_START;
                    stage_next.res.tx_valid   = 1'b1;
                    stage_next.res.tx_byte    = cfg.read_address;
                end
                SC_ADDR_W_ACK: begin
                    write_position_next     = pos_inc;
                    buf_rd_addr             = pos_inc;
                    stage_next.res.tx_valid = 1'b1;
                    stage_next.tx_from_buf  = 1'b1;
                    write_remaining_next    = (write_remaining_reg >= ADDR_ACK_STEP) ?
                                              write_remaining_reg - ADDR_ACK_STEP : '0;
                end
                SC_DATA_W_ACK: begin
                    if (write_remaining_reg != '0) begin
                        write_position_next     = pos_inc;
                        buf_rd_addr             = pos_inc;
                        stage_next.res.tx_valid = 1'b1;
                        stage_next.tx_from_buf  = 1'b1;
                        write_remaining_next    = write_remaining_reg - 8'd1;
                    end else if (repeat_pending_reg) begin
                        repeat_pending_next       = 1'b0;
                        stage_next.res.bus_action = ACT_RESTART;
                    end else begin
                        status_now_next           = ST_OK;
                        stage_next.res.bus_action = ACT_STOP;
                    end
                end
                SC_ADDR_W_NACK, SC_DATA_W_NACK, SC_ADDR_R_NACK: begin
                    stage_next.res.bus_action = ACT_STOP;
                    status_now_next           = ST_ERROR;
                end
                SC_ARB_LOST: begin
                    stage_next.res.bus_action = ACT_STOP;
                end
                SC_ADDR_R_ACK: begin
                    stage_next.res.bus_action = ACT_ACK;
                end
                SC_DATA_R_ACK: begin
                    stage_next.res.rx_valid = 1'b1;
                    stage_next.res.rx_index = read_position_reg;
                    stage_next.res.rx_byte  = item.data_byte;
                    if (read_remaining_reg <= 8'd1) begin
                        stage_next.res.bus_action = ACT_STOP;
                        status_now_next           = ST_OK;
                    end
                    read_position_next = read_position_reg + 8'd1;
                    if (read_remaining_reg != '0) begin
                        read_remaining_next = read_remaining_reg - 8'd1;
                    end
                end
                SC_DATA_R_NACK: begin
                    stage_next.res.rx_valid   = 1'b1;
                    stage_next.res.rx_index   = read_position_reg;
                    stage_next.res.rx_byte    = item.data_byte;
                    stage_next.res.bus_action = ACT_STOP;
                    status_now_next           = ST_OK;
                end
                default: begin
                    stage_next.res.bus_action = ACT_STOP;
                    status_now_next           = ST_ERROR;
                end
            endcase
        end
        stage_next.res.transfer_status = status_now_next;
    end

    // stage holds a result until the output side takes it
    assign stage_valid_next = is_event || (stage_valid_reg && !stage_ready);

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_position_reg  <= '0;
            write_remaining_reg <= '0;
            read_remaining_reg  <= '0;
            read_position_reg   <= '0;
            repeat_pending_reg  <= 1'b0;
            status_now_reg      <= ST_BUSY;
            stage_valid_reg     <= 1'b0;
        end else begin
            write_position_reg  <= write_position_next;
            write_remaining_reg <= write_remaining_next;
            read_remaining_reg  <= read_remaining_next;
            read_position_reg   <= read_position_next;
            repeat_pending_reg  <= repeat_pending_next;
            status_now_reg      <= status_now_next;
            stage_valid_reg     <= stage_valid_next;
        end
    end

    // result stage payload
    always_ff @(posedge aclk) begin
        if (is_event) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

`default_nettype wire

// ===== hdl/i2cmes_skid.sv =====
`default_nettype none

module i2cmes_skid (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire i2cmes_pkg::result_t in_data,
    output logic                     in_ready,
    output logic                     out_valid,
    output i2cmes_pkg::result_t      out_data,
    input  wire logic                out_ready
);

    import i2cmes_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (main_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (out_ready) begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_ready) begin
                main_reg <= skid_reg;
            end
        end else if (in_fire) begin
            if (main_valid_reg && !out_ready) begin
                skid_reg <= in_data;
            end else begin
                main_reg <= in_data;
            end
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

`default_nettype wire

// ===== hdl/i2c_master_event_sequencer_unit.sv =====
`default_nettype none

// I2C master transaction sequencer. Load the write buffer with opcode 0
// items (slave address byte first), set the configuration registers, send a
// start item (opcode 1), then forward each bus controller status code as an
// event item (opcode 2); every event gives exactly one result with the byte
// to transmit, the bus action, any received byte and the transfer status.
// Load and start items give no result. One item is accepted per cycle unless
// the result stage is stalled; an event's result is registered in the decode
// stage, where the write buffer's registered read port delivers the transmit
// byte, and then in the output buffer. A two-entry output buffer keeps
// s_tready off any combinational path from m_tready. Configuration writes
// are always accepted and take effect on the next item.
module i2c_master_event_sequencer_unit #(
    parameter int WRITE_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // status_code, data_byte, buffer_index, zero pad
    input  wire logic [1:0]  s_tuser,  // opcode
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // tx_byte, bus_action, rx_index, rx_byte,
                                       // transfer_status, zero pad
    output logic [1:0]       m_tuser   // tx_valid, rx_valid
);

    import i2cmes_pkg::*;

    localparam int PW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

    cfg_t          cfg_reg;
    item_t         item;
    logic          s_accept;
    logic          stage_valid;
    stage_t        stage;
    logic          out_ready;
    logic          buf_wr_en;
    logic [PW-1:0] buf_wr_addr;
    logic          buf_rd_en;
    logic [PW-1:0] buf_rd_addr;
    logic [7:0]    buf_rd_data;
    result_t       stage_res;
    result_t       out_res;

    assign item.opcode       = s_tuser;
    assign item.status_code  = s_tdata[7:0];
    assign item.data_byte    = s_tdata[15:8];
    assign item.buffer_index = s_tdata[19:16];

    assign s_tready  = !stage_valid || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.write_count         <= 5'd1;
            cfg_reg.read_count          <= '0;
            cfg_reg.repeat_start_enable <= 1'b0;
            cfg_reg.read_address        <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WRITE_COUNT:  cfg_reg.write_count         <= cfg_data[4:0];
                CFG_READ_COUNT:   cfg_reg.read_count          <= cfg_data;
                CFG_REPEAT_START: cfg_reg.repeat_start_enable <= cfg_data[0];
                CFG_READ_ADDRESS: cfg_reg.read_address        <= cfg_data;
                default: ;
            endcase
        end
    end

    i2cmes_ctrl #(
        .WRITE_DEPTH (WRITE_DEPTH),
        .PW          (PW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (s_accept),
        .item        (item),
        .cfg         (cfg_reg),
        .stage_ready (out_ready),
        .stage_valid (stage_valid),
        .stage       (stage),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_rd_en   (buf_rd_en),
        .buf_rd_addr (buf_rd_addr)
    );

    i2cmes_wbuf #(
        .WRITE_DEPTH (WRITE_DEPTH),
        .PW          (PW)
    ) u_wbuf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (item.data_byte),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    // merge buffer read data into the staged result
    always_comb begin
        stage_res = stage.res;
        if (stage.tx_from_buf) begin
            stage_res.tx_byte = buf_rd_data;
        end
    end

    i2cmes_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid),
        .in_data   (stage_res),
        .in_ready  (out_ready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'd0, out_res.transfer_status, out_res.rx_byte, out_res.rx_index,
                      out_res.bus_action, out_res.tx_byte};
    assign m_tuser = {out_res.rx_valid, out_res.tx_valid};

    // a stalled stage must block new items
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid && !out_ready) |-> !s_tready)
        else $error("input accepted while result stage is stalled");

    // every accepted event lands in the result stage
    a_event_staged: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == OP_EVENT)) |=> stage_valid)
        else $error("accepted event did not reach result stage");

    // received fields are zero unless a byte was received
    a_rx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[26:11] == '0))
        else $error("rx fields set without rx_valid");

    // a repeated start never carries a byte to transmit
    a_restart_no_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[10:8] == ACT_RESTART)) |-> !m_tuser[0])
        else $error("repeated start with tx_valid");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmes_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [7:0] SC_UNKNOWN_TOP = 8'hFF;
    localparam logic [7:0] SC_UNKNOWN_LOW = 8'h00;

    localparam int DEPTH        = 16;
    localparam int GAP_MAX      = 17;
    localparam int SETTLE_LEN   = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 140;
    localparam int NUM_PHASES   = 8;
    localparam int NUM_DIRECTED = 22;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    always #4 aclk = ~aclk;

    i2c_master_event_sequencer_unit #(
        .WRITE_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow copy of the sequencer state and registers
    logic [7:0]       tx_bytes [DEPTH];
    bit [DEPTH-1:0]   slot_loaded = '0;
    logic [3:0]       tx_pos      = '0;
    logic [7:0]       tx_left     = '0;
    logic [7:0]       rx_left     = '0;
    logic [7:0]       rx_pos      = '0;
    bit               restart_armed = 1'b0;
    logic [1:0]       xfer_state  = ST_BUSY;
    cfg_t             regs        = '{5'd1, 8'd0, 1'b0, 8'd0};

    result_t results_due [$];
    int      error_count  = 0;
    int      items_sent   = 0;
    int      rx_gap_left  = 0;
    int      rx_hold_left = 0;
    bit      tx_quiet     = 1'b0;
    bit      rx_quiet     = 1'b0;

    typedef struct packed {
        item_t   it;
        bit      typed;
        result_t want;
    } directed_row_t;

    // directed items: events outside a transfer, unused opcode, a short write
    // transfer with saturating count, all nack codes, then a restarted write
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{OP_EVENT, SC_ARB_LOST, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b0, 8'h00, 8'h00, ST_BUSY}},
        '{'{OP_EVENT, SC_ADDR_R_ACK, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_ACK, 1'b0, 8'h00, 8'h00, ST_BUSY}},
        '{'{OP_EVENT, SC_DATA_R_ACK, 8'hFF, 4'hF}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b1, 8'h00, 8'hFF, ST_OK}},
        '{'{OP_EVENT, SC_DATA_R_NACK, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b1, 8'h01, 8'h00, ST_OK}},
        '{'{OP_EVENT, SC_RESTART, 8'h00, 4'h0}, 1'b1,
          '{1'b1, 8'h00, ACT_CLEAR_START, 1'b0, 8'h00, 8'h00, ST_OK}},
        '{'{OP_EVENT, SC_UNKNOWN_TOP, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b0, 8'h00, 8'h00, ST_ERROR}},
        '{'{OP_EVENT, SC_UNKNOWN_LOW, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b0, 8'h00, 8'h00, ST_ERROR}},
        '{'{OP_UNUSED, 8'h5A, 8'hA5, 4'hF}, 1'b0, '0},
        '{'{OP_LOAD, 8'hFF, 8'hA4, 4'h0}, 1'b0, '0},
        '{'{OP_LOAD, 8'h00, 8'hFF, 4'h1}, 1'b0, '0},
        '{'{OP_LOAD, 8'h00, 8'h00, 4'h2}, 1'b0, '0},
        '{'{OP_LOAD, 8'h00, 8'h5A, 4'hF}, 1'b0, '0},
        '{'{OP_START, 8'hFF, 8'hFF, 4'hF}, 1'b0, '0},
        '{'{OP_EVENT, SC_START, 8'h00, 4'h0}, 1'b1,
          '{1'b1, 8'hA4, ACT_CLEAR_START, 1'b0, 8'h00, 8'h00, ST_BUSY}},
        '{'{OP_EVENT, SC_ADDR_W_ACK, 8'h00, 4'h0}, 1'b1,
          '{1'b1, 8'hFF, ACT_NONE, 1'b0, 8'h00, 8'h00, ST_BUSY}},
        '{'{OP_EVENT, SC_DATA_W_ACK, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b0, 8'h00, 8'h00, ST_OK}},
        '{'{OP_EVENT, SC_ADDR_W_NACK, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b0, 8'h00, 8'h00, ST_ERROR}},
        '{'{OP_EVENT, SC_DATA_W_NACK, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b0, 8'h00, 8'h00, ST_ERROR}},
        '{'{OP_EVENT, SC_ADDR_R_NACK, 8'h00, 4'h0}, 1'b1,
          '{1'b0, 8'h00, ACT_STOP, 1'b0, 8'h00, 8'h00, ST_ERROR}},
        '{'{OP_START, 8'h00, 8'h00, 4'h0}, 1'b0, '0},
        '{'{OP_EVENT, SC_DATA_W_ACK, 8'h00, 4'h0}, 1'b0, '0},
        '{'{OP_EVENT, SC_ADDR_W_ACK, 8'h00, 4'h0}, 1'b0, '0}
    };

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] rnd4();
        return 4'($urandom_range(0, 15));
    endfunction

    // advance the shadow sequencer by one item, giving the bus result if any
    task automatic step_sequencer(input item_t it, output bit produces, output result_t r);
        r = '0;
        produces = 1'b0;
        case (it.opcode)
            OP_LOAD: begin
                tx_bytes[it.buffer_index] = it.data_byte;
                slot_loaded[it.buffer_index] = 1'b1;
            end
            OP_START: begin
                tx_pos = '0;
                tx_left = {3'b000, regs.write_count};
                rx_left = regs.read_count;
                rx_pos = '0;
                restart_armed = regs.repeat_start_enable;
                xfer_state = ST_BUSY;
            end
            OP_EVENT: begin
                produces = 1'b1;
                case (it.status_code)
                    SC_START: begin
                        r.bus_action = ACT_CLEAR_START;
                        r.tx_valid = 1'b1;
                        r.tx_byte = tx_bytes[tx_pos];
                    end
                    SC_RESTART: begin
                        r.bus_action = ACT_CLEAR_START;
                        r.tx_valid = 1'b1;
                        r.tx_byte = regs.read_address;
                    end
                    SC_ADDR_W_ACK: begin
                        tx_pos = tx_pos + 4'd1;
                        r.tx_valid = 1'b1;
                        r.tx_byte = tx_bytes[tx_pos];
                        tx_left = (tx_left >= ADDR_ACK_STEP) ? tx_left - ADDR_ACK_STEP : '0;
                    end
                    SC_DATA_W_ACK: begin
                        if (tx_left != 0) begin
                            tx_pos = tx_pos + 4'd1;
                            r.tx_valid = 1'b1;
                            r.tx_byte = tx_bytes[tx_pos];
                            tx_left = tx_left - 8'd1;
                        end else if (restart_armed) begin
                            restart_armed = 1'b0;
                            r.bus_action = ACT_RESTART;
                        end else begin
                            xfer_state = ST_OK;
                            r.bus_action = ACT_STOP;
                        end
                    end
                    SC_ADDR_W_NACK, SC_DATA_W_NACK, SC_ADDR_R_NACK: begin
                        r.bus_action = ACT_STOP;
                        xfer_state = ST_ERROR;
                    end
                    SC_ARB_LOST: r.bus_action = ACT_STOP;
                    SC_ADDR_R_ACK: r.bus_action = ACT_ACK;
                    SC_DATA_R_ACK: begin
                        r.rx_valid = 1'b1;
                        r.rx_index = rx_pos;
                        r.rx_byte = it.data_byte;
                        if (rx_left <= 8'd1) begin
                            r.bus_action = ACT_STOP;
                            xfer_state = ST_OK;
                        end
                        rx_pos = rx_pos + 8'd1;
                        if (rx_left != 0) rx_left = rx_left - 8'd1;
                    end
                    SC_DATA_R_NACK: begin
                        r.rx_valid = 1'b1;
                        r.rx_index = rx_pos;
                        r.rx_byte = it.data_byte;
                        r.bus_action = ACT_STOP;
                        xfer_state = ST_OK;
                    end
                    default: begin
                        r.bus_action = ACT_STOP;
                        xfer_state = ST_ERROR;
                    end
                endcase
                r.transfer_status = xfer_state;
            end
            default: ;
        endcase
    endtask

    // offer one item after a random gap and log its expected result on accept
    task automatic offer_item(input item_t it, input bit typed, input result_t want);
        int gap;
        bit produces;
        result_t predicted;
        gap = (tx_quiet || rx_hold_left > 0) ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 23) == 0) tx_quiet = !tx_quiet;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.opcode;
        s_tdata  <= {4'b0000, it.buffer_index, it.data_byte, it.status_code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_sequencer(it, produces, predicted);
        if (produces) results_due.push_back(typed ? want : predicted);
        if (it.opcode != OP_UNUSED) items_sent++;
    endtask

    task automatic send(input logic [1:0] op, input logic [7:0] code,
                        input logic [7:0] data, input logic [3:0] slot);
        offer_item('{opcode: op, status_code: code, data_byte: data, buffer_index: slot},
                   1'b0, '0);
    endtask

    // status event; a buffer slot that the event reads is loaded first if empty
    task automatic send_event(input logic [7:0] code);
        logic [3:0] slot;
        bit reads;
        slot = tx_pos + 4'd1;
        case (code)
            SC_START: begin
                reads = 1'b1;
                slot = tx_pos;
            end
            SC_ADDR_W_ACK: reads = 1'b1;
            SC_DATA_W_ACK: reads = (tx_left != 0);
            default:       reads = 1'b0;
        endcase
        if (reads && !slot_loaded[slot]) send(OP_LOAD, rnd8(), rnd8(), slot);
        send(OP_EVENT, code, rnd8(), rnd4());
    endtask

    // occasionally break a transfer with a failure event
    task automatic maybe_abort(input bit may_abort, output bit hit);
        hit = may_abort && ($urandom_range(0, 24) == 0);
        if (hit) begin
            case ($urandom_range(0, 4))
                0:       send_event(SC_ADDR_W_NACK);
                1:       send_event(SC_DATA_W_NACK);
                2:       send_event(SC_ADDR_R_NACK);
                3:       send_event(SC_ARB_LOST);
                default: send_event(rnd8());
            endcase
        end
    endtask

    // one well-formed transfer with random content
    task automatic run_transfer(input int extra_reads, input bit may_abort);
        bit will_restart;
        bit hit;
        int i;
        for (i = 0; i < regs.write_count; i++)
            if ($urandom_range(0, 3) != 0) send(OP_LOAD, rnd8(), rnd8(), 4'(i));
        send(OP_START, rnd8(), rnd8(), rnd4());
        send_event(SC_START);
        maybe_abort(may_abort, hit);
        if (hit) return;
        send_event(SC_ADDR_W_ACK);
        while (tx_left != 0) begin
            maybe_abort(may_abort, hit);
            if (hit) return;
            send_event(SC_DATA_W_ACK);
        end
        will_restart = restart_armed;
        send_event(SC_DATA_W_ACK);
        if (!will_restart) return;
        send_event(SC_RESTART);
        maybe_abort(may_abort, hit);
        if (hit) return;
        send_event(SC_ADDR_R_ACK);
        while (rx_left > 8'd1) begin
            maybe_abort(may_abort, hit);
            if (hit) return;
            send_event(SC_DATA_R_ACK);
        end
        send_event($urandom_range(0, 1) ? SC_DATA_R_ACK : SC_DATA_R_NACK);
        repeat (extra_reads) send_event(SC_DATA_R_ACK);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0, 1:    send_event(rnd8());
            2:       send(OP_UNUSED, rnd8(), rnd8(), rnd4());
            3:       send(OP_START, rnd8(), rnd8(), rnd4());
            default: send(OP_LOAD, rnd8(), rnd8(), rnd4());
        endcase
    endtask

    // stop offering, wait for every result, then let the pipeline go quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_LEN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_WRITE_COUNT:  regs.write_count = value[4:0];
            CFG_READ_COUNT:   regs.read_count = value;
            CFG_REPEAT_START: regs.repeat_start_enable = value[0];
            CFG_READ_ADDRESS: regs.read_address = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_registers(input cfg_t setting);
        settle();
        write_reg(CFG_WRITE_COUNT, {3'b000, setting.write_count});
        write_reg(CFG_READ_COUNT, setting.read_count);
        write_reg(CFG_REPEAT_START, {7'b0, setting.repeat_start_enable});
        write_reg(CFG_READ_ADDRESS, setting.read_address);
    endtask

    // compare one bus result with the oldest expectation, field by field
    task automatic check_result(input result_t got);
        result_t want;
        string names [7] = '{"tx_valid", "tx_byte", "bus_action", "rx_valid",
                             "rx_index", "rx_byte", "transfer_status"};
        int w [7];
        int g [7];
        if (results_due.size() == 0) begin
            $display("%0t: result with none expected: expected nothing, got tdata %h tuser %b",
                     $time, m_tdata, m_tuser);
            error_count++;
            return;
        end
        want = results_due.pop_front();
        w = '{want.tx_valid, want.tx_byte, want.bus_action, want.rx_valid,
              want.rx_index, want.rx_byte, want.transfer_status};
        g = '{got.tx_valid, got.tx_byte, got.bus_action, got.rx_valid,
              got.rx_index, got.rx_byte, got.transfer_status};
        foreach (w[f]) begin
            if (w[f] != g[f]) begin
                $display("%0t: %s expected %0h got %0h", $time, names[f], w[f], g[f]);
                error_count++;
            end
        end
    endtask

    // result side: accept and check at the rising edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_result('{tx_valid: m_tuser[0], tx_byte: m_tdata[7:0],
                               bus_action: m_tdata[10:8], rx_valid: m_tuser[1],
                               rx_index: m_tdata[18:11], rx_byte: m_tdata[26:19],
                               transfer_status: m_tdata[28:27]});
                rx_gap_left = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
                if ($urandom_range(0, 23) == 0) rx_quiet = !rx_quiet;
            end
        end
    end

    // result side ready: long hold first, then per-item stall
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else if (rx_gap_left > 0) begin
                m_tready <= 1'b0;
                rx_gap_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int p;
        int phase_end;
        cfg_t setting;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++)
            offer_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: setting = '{5'd1, 8'd0, 1'b0, 8'h00};
                1: setting = '{5'd16, 8'd255, 1'b1, 8'hFF};
                default: begin
                    setting.write_count = 5'($urandom_range(1, 16));
                    setting.read_count = ($urandom_range(0, 3) == 0) ? rnd8()
                                                                     : 8'($urandom_range(0, 12));
                    setting.repeat_start_enable = 1'($urandom_range(0, 1));
                    setting.read_address = rnd8();
                end
            endcase
            program_registers(setting);
            // long receiver hold while the sender keeps pushing
            if (p == 3) rx_hold_left = HOLD_CYCLES;
            // full-length read that runs the read position past its wrap
            if (p == 1) run_transfer(8, 1'b0);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0) send_noise();
                else run_transfer(0, 1'b1);
            end
        end

        settle();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/i2cmes_pkg.sv
hdl/i2cmes_wbuf.sv
hdl/i2cmes_ctrl.sv
hdl/i2cmes_skid.sv
hdl/i2c_master_event_sequencer_unit.sv
dv/tb.sv
